// ----- design/pmul_pkg.sv -----
package pmul_pkg;

   localparam int MAX_EXP    = 15;
   localparam int COEF_WIDTH = 16;

   localparam int POLY_DEPTH = MAX_EXP + 1;
   localparam int IN_COEF_W  = 16;
   localparam int EXPO_IN_W  = 6;
   localparam int OUT_COEF_W = 40;
   localparam int EXPO_OUT_W = 5;
   localparam int PROD_W     = 2 * COEF_WIDTH;
   localparam int ACC_W      = PROD_W + $clog2(POLY_DEPTH);
   localparam int SAT_W      = (ACC_W > OUT_COEF_W) ? ACC_W : OUT_COEF_W;
   localparam int CLAMP_W    = ((COEF_WIDTH > IN_COEF_W) ? COEF_WIDTH : IN_COEF_W) + 1;
   localparam int CNT_W      = $clog2(2 * POLY_DEPTH + 1);

   localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [1:0] CMD_MULTIPLY    = 2'd2;

   // walk counter marks: pipeline depth, end of feed, final step
   localparam logic [CNT_W-1:0] LAT_CNT  = CNT_W'(2);
   localparam logic [CNT_W-1:0] FEED_CNT = CNT_W'(POLY_DEPTH);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * POLY_DEPTH);

   localparam logic signed [CLAMP_W-1:0] COEF_MAX_EXT =
      {{(CLAMP_W - COEF_WIDTH + 1){1'b0}}, {(COEF_WIDTH - 1){1'b1}}};
   localparam logic signed [CLAMP_W-1:0] COEF_MIN_EXT =
      {{(CLAMP_W - COEF_WIDTH + 1){1'b1}}, {(COEF_WIDTH - 1){1'b0}}};

   localparam logic signed [SAT_W-1:0] OUT_MAX_EXT =
      {{(SAT_W - OUT_COEF_W + 1){1'b0}}, {(OUT_COEF_W - 1){1'b1}}};
   localparam logic signed [SAT_W-1:0] OUT_MIN_EXT =
      {{(SAT_W - OUT_COEF_W + 1){1'b1}}, {(OUT_COEF_W - 1){1'b0}}};

   typedef struct packed {
      logic [1:0]                  command;
      logic signed [IN_COEF_W-1:0] coef_in;
      logic [EXPO_IN_W-1:0]        expo_in;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_COEF_W-1:0] coef_out;
      logic [EXPO_OUT_W-1:0]        expo_out;
      logic                         last_term;
      logic                         empty_product;
      logic                         overflow;
   } rsp_word_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic shift;
      logic load_first;
      logic load_second;
   } cell_ctrl_type;

   typedef struct packed {
      logic sample;
      logic finish;
      logic overflow;
   } out_ctrl_type;

endpackage

// ----- design/pmul_cell.sv -----
module pmul_cell
   import pmul_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic signed [COEF_WIDTH-1:0] coef,
   input  logic signed [COEF_WIDTH-1:0] x,
   input  logic signed [COEF_WIDTH-1:0] second_prev,
   input  logic signed [ACC_W-1:0]      acc_prev,
   output logic signed [COEF_WIDTH-1:0] second_out,
   output logic signed [ACC_W-1:0]      acc_out,
   output logic                         sat
);

   logic signed [COEF_WIDTH-1:0] first_ff;
   logic signed [COEF_WIDTH-1:0] second_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;

   logic signed [COEF_WIDTH-1:0] target;
   logic signed [COEF_WIDTH:0]   sum_val;
   logic                         sum_ovf;
   logic signed [COEF_WIDTH-1:0] sum_sat;
   logic signed [PROD_W-1:0]     prod_in;
   logic signed [ACC_W-1:0]      acc_in;

   assign target  = ctrl.load_first ? first_ff : second_ff;
   assign sum_val = (COEF_WIDTH + 1)'(target) + (COEF_WIDTH + 1)'(coef);
   assign sum_ovf = sum_val[COEF_WIDTH] ^ sum_val[COEF_WIDTH-1];
   assign sum_sat = sum_ovf ? {sum_val[COEF_WIDTH], {(COEF_WIDTH - 1){~sum_val[COEF_WIDTH]}}}
                            : sum_val[COEF_WIDTH-1:0];
   assign sat     = (ctrl.load_first || ctrl.load_second) && sum_ovf;

   assign prod_in = PROD_W'(first_ff) * PROD_W'(x);
   assign acc_in  = acc_prev + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         first_ff  <= '0;
         second_ff <= '0;
         prod_ff   <= '0;
         acc_ff    <= '0;
      end else begin
         if (ctrl.load_first) begin
            first_ff <= sum_sat;
         end
         if (ctrl.load_second) begin
            second_ff <= sum_sat;
         end else if (ctrl.shift) begin
            second_ff <= second_prev;
         end
         if (ctrl.step) begin
            prod_ff <= prod_in;
            acc_ff  <= acc_in;
         end
      end
   end

   assign second_out = second_ff;
   assign acc_out    = acc_ff;

endmodule

// ----- design/pmul_out.sv -----
module pmul_out
   import pmul_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  out_ctrl_type                 ctrl,
   input  logic signed [OUT_COEF_W-1:0] coef,
   input  logic [EXPO_OUT_W-1:0]        expo,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output rsp_word_type                 rsp_word,
   output logic                         free
);

   logic                         valid_ff, valid_in;
   rsp_word_type                 word_ff, word_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic signed [OUT_COEF_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXPO_OUT_W-1:0]        pend_expo_ff, pend_expo_in;

   assign free = !valid_ff || !rsp_stall;

   // one term of lookahead: a term is known to be last only at the end of the walk
   always_comb begin
      valid_in      = valid_ff && rsp_stall;
      word_in       = word_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_expo_in  = pend_expo_ff;
      if (ctrl.sample && coef != '0) begin
         pend_valid_in = 1'b1;
         pend_coef_in  = coef;
         pend_expo_in  = expo;
         if (pend_valid_ff) begin
            valid_in = 1'b1;
            word_in  = '{coef_out: pend_coef_ff, expo_out: pend_expo_ff, last_term: 1'b0,
                         empty_product: 1'b0, overflow: ctrl.overflow};
         end
      end else if (ctrl.finish) begin
         valid_in      = 1'b1;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            word_in = '{coef_out: pend_coef_ff, expo_out: pend_expo_ff, last_term: 1'b1,
                        empty_product: 1'b0, overflow: ctrl.overflow};
         end else begin
            word_in = '{coef_out: '0, expo_out: '0, last_term: 1'b1,
                        empty_product: 1'b1, overflow: ctrl.overflow};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      word_ff      <= word_in;
      pend_coef_ff <= pend_coef_in;
      pend_expo_ff <= pend_expo_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ----- design/polynomial_multiplier_core.sv -----
// Term loads: one word per cycle while idle (req_stall holds them off during a multiply), no result word.
// Multiply: a scan walk and then an emit walk over the cell chain, then one closing finish step;
// the emit walk and the finish step wait whenever rsp_stall holds the output word.
// Each walk length is set by the coefficient chain: one exponent fed per cycle, except while the emit walk waits.
// Synchronous reset clears both polynomials, the product chain and the overflow flag.
module polynomial_multiplier_core
   import pmul_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT, ST_FINISH} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;

   logic                         accept;
   logic                         is_load, load_first_ok, load_second_ok, drop;
   logic signed [CLAMP_W-1:0]    coef_ext;
   logic                         clamp_hi, clamp_lo;
   logic signed [COEF_WIDTH-1:0] coef_cl;
   logic                         step, feed, clear;
   logic signed [COEF_WIDTH-1:0] x_eff;
   logic [POLY_DEPTH-1:0]        sat_vec;
   logic signed [ACC_W-1:0]      y;
   logic signed [SAT_W-1:0]      y_ext;
   logic                         y_hi, y_lo;
   logic signed [OUT_COEF_W-1:0] y_sat;
   out_ctrl_type                 out_ctrl;
   logic                         out_free;

   logic signed [COEF_WIDTH-1:0] second_chain [POLY_DEPTH];
   logic signed [ACC_W-1:0]      acc_chain [POLY_DEPTH];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign is_load        = accept && (req_word.command == CMD_LOAD_FIRST ||
                                      req_word.command == CMD_LOAD_SECOND);
   assign drop           = is_load && (req_word.expo_in > EXPO_IN_W'(MAX_EXP));
   assign load_first_ok  = is_load && !drop && req_word.command == CMD_LOAD_FIRST;
   assign load_second_ok = is_load && !drop && req_word.command == CMD_LOAD_SECOND;

   assign coef_ext = CLAMP_W'(req_word.coef_in);
   assign clamp_hi = coef_ext > COEF_MAX_EXT;
   assign clamp_lo = coef_ext < COEF_MIN_EXT;
   assign coef_cl  = clamp_hi ? COEF_MAX_EXT[COEF_WIDTH-1:0] :
                     clamp_lo ? COEF_MIN_EXT[COEF_WIDTH-1:0] : coef_ext[COEF_WIDTH-1:0];

   assign x_eff = feed ? second_chain[POLY_DEPTH-1] : '0;

   for (genvar k = 0; k < POLY_DEPTH; k++) begin : g_cell
      logic signed [COEF_WIDTH-1:0] second_prev;
      logic signed [ACC_W-1:0]      acc_prev;
      cell_ctrl_type                cell_ctrl;
      logic                         hit;

      if (k == 0) begin : g_head
         assign second_prev = second_chain[POLY_DEPTH-1];
         assign acc_prev    = '0;
      end else begin : g_body
         assign second_prev = second_chain[k-1];
         assign acc_prev    = acc_chain[k-1];
      end

      assign hit       = (req_word.expo_in == EXPO_IN_W'(k));
      assign cell_ctrl = '{clear: clear, step: step, shift: feed && step,
                           load_first: load_first_ok && hit,
                           load_second: load_second_ok && hit};

      pmul_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .coef        (coef_cl),
         .x           (x_eff),
         .second_prev (second_prev),
         .acc_prev    (acc_prev),
         .second_out  (second_chain[k]),
         .acc_out     (acc_chain[k]),
         .sat         (sat_vec[k])
      );
   end

   assign y     = acc_chain[POLY_DEPTH-1];
   assign y_ext = SAT_W'(y);
   assign y_hi  = y_ext > OUT_MAX_EXT;
   assign y_lo  = y_ext < OUT_MIN_EXT;
   assign y_sat = y_hi ? OUT_MAX_EXT[OUT_COEF_W-1:0] :
                  y_lo ? OUT_MIN_EXT[OUT_COEF_W-1:0] : y_ext[OUT_COEF_W-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff || drop || ((load_first_ok || load_second_ok) && (clamp_hi || clamp_lo))
                 || (|sat_vec);
      step     = 1'b1;
      feed     = 1'b0;
      clear    = 1'b0;
      out_ctrl = '{sample: 1'b0, finish: 1'b0, overflow: ovf_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.command == CMD_MULTIPLY) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            feed   = cnt_ff < FEED_CNT;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff >= LAT_CNT && (y_hi || y_lo)) begin
               ovf_in = 1'b1;
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            step = out_free;
            feed = cnt_ff < FEED_CNT;
            if (out_free) begin
               out_ctrl.sample = cnt_ff >= LAT_CNT;
               cnt_in          = cnt_ff + CNT_W'(1);
               if (cnt_ff == LAST_CNT) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_ctrl.finish = 1'b1;
               clear           = 1'b1;
               ovf_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   pmul_out u_out (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (out_ctrl),
      .coef      (y_sat),
      .expo      (EXPO_OUT_W'(LAST_CNT - cnt_ff)),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .free      (out_free)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_product |-> rsp_word.last_term && rsp_word.coef_out == '0)
      else $error("empty product word malformed");

   a_term_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.empty_product |-> rsp_word.coef_out != '0)
      else $error("zero product term emitted");

   a_chain_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> y == '0)
      else $error("product chain not flushed while idle");

   a_ovf_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && out_free |=> !ovf_ff)
      else $error("overflow flag survived multiply");

   a_scan_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !out_ctrl.sample && !out_ctrl.finish)
      else $error("output written during scan walk");

endmodule

// ----- verif/polynomial_multiplier_core_tb.sv -----
`timescale 1ns / 1ps

module polynomial_multiplier_core_tb;
   import pmul_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int PROD_TOP = 2 * MAX_EXP;
   localparam longint COEF_HI = (longint'(1) << (COEF_WIDTH - 1)) - 1;
   localparam longint COEF_LO = -COEF_HI - 1;
   localparam longint OUT_HI = (longint'(1) << (OUT_COEF_W - 1)) - 1;
   localparam longint OUT_LO = -OUT_HI - 1;
   localparam int WORD_TARGET = 330;
   localparam int DRAIN_CYCLES = 120;
   localparam int LONG_HOLD = 400;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type term;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   logic signed [COEF_WIDTH-1:0] first_terms [POLY_DEPTH];
   logic signed [COEF_WIDTH-1:0] second_terms [POLY_DEPTH];
   bit                           pend_overflow;

   rsp_word_type pending_terms[$];
   stim_row_type plan[$];

   int  fail_count = 0;
   int  words_sent = 0;
   int  products_sent = 0;
   int  terms_checked = 0;
   int  empties_checked = 0;
   int  burst_left = 0;
   bit  hold_pending = 1'b0;
   bit  mid_pause_done = 1'b0;

   polynomial_multiplier_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic rsp_word_type mk_term(input longint coef, input int expo, input bit last,
                                            input bit empty, input bit ovf);
      rsp_word_type t;
      t.coef_out      = OUT_COEF_W'(coef);
      t.expo_out      = EXPO_OUT_W'(expo);
      t.last_term     = last;
      t.empty_product = empty;
      t.overflow      = ovf;
      return t;
   endfunction

   function automatic longint sat_coef(input longint v);
      if (v > COEF_HI) begin
         pend_overflow = 1'b1;
         return COEF_HI;
      end
      if (v < COEF_LO) begin
         pend_overflow = 1'b1;
         return COEF_LO;
      end
      return v;
   endfunction

   function automatic void clear_terms();
      foreach (first_terms[e]) begin
         first_terms[e]  = '0;
         second_terms[e] = '0;
      end
      pend_overflow = 1'b0;
   endfunction

   function automatic void predict_word(input req_word_type w, output rsp_word_type terms[$]);
      longint prod [PROD_TOP+1];
      longint c;
      int     lowest;
      terms = {};
      case (w.command)
         CMD_LOAD_FIRST, CMD_LOAD_SECOND: begin
            if (w.expo_in > EXPO_IN_W'(MAX_EXP)) begin
               pend_overflow = 1'b1;
            end else begin
               c = sat_coef(longint'(w.coef_in));
               if (w.command == CMD_LOAD_FIRST)
                  first_terms[w.expo_in] =
                     COEF_WIDTH'(sat_coef(longint'(first_terms[w.expo_in]) + c));
               else
                  second_terms[w.expo_in] =
                     COEF_WIDTH'(sat_coef(longint'(second_terms[w.expo_in]) + c));
            end
         end
         CMD_MULTIPLY: begin
            foreach (prod[e]) prod[e] = 0;
            for (int i = 0; i < POLY_DEPTH; i++)
               for (int j = 0; j < POLY_DEPTH; j++)
                  prod[i+j] += longint'(first_terms[i]) * longint'(second_terms[j]);
            lowest = -1;
            for (int e = PROD_TOP; e >= 0; e--) begin
               if (prod[e] > OUT_HI) begin
                  prod[e] = OUT_HI;
                  pend_overflow = 1'b1;
               end
               if (prod[e] < OUT_LO) begin
                  prod[e] = OUT_LO;
                  pend_overflow = 1'b1;
               end
               if (prod[e] != 0) lowest = e;
            end
            if (lowest < 0) begin
               terms.push_back(mk_term(0, 0, 1'b1, 1'b1, pend_overflow));
            end else begin
               for (int e = PROD_TOP; e >= 0; e--)
                  if (prod[e] != 0)
                     terms.push_back(mk_term(prod[e], e, e == lowest, 1'b0, pend_overflow));
            end
            clear_terms();
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] cmd, input int coef, input int expo,
                                   input bit typed = 1'b0, input rsp_word_type term = '0);
      stim_row_type r;
      r.word.command = cmd;
      r.word.coef_in = IN_COEF_W'(coef);
      r.word.expo_in = EXPO_IN_W'(expo);
      r.typed        = typed;
      r.term         = term;
      plan.push_back(r);
   endfunction

   function automatic logic signed [IN_COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return IN_COEF_W'($urandom);
         default: return IN_COEF_W'(int'($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   function automatic logic [EXPO_IN_W-1:0] pick_expo();
      if ($urandom_range(0, 11) == 0)
         return EXPO_IN_W'($urandom_range(MAX_EXP + 1, 63));
      return EXPO_IN_W'($urandom_range(0, MAX_EXP));
   endfunction

   task automatic send_word(input req_word_type w, input bit typed = 1'b0,
                            input rsp_word_type typed_term = '0);
      rsp_word_type terms[$];
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_word(w, terms);
      if (w.command == CMD_MULTIPLY) begin
         products_sent++;
         if (typed) pending_terms.push_back(typed_term);
         else foreach (terms[k]) pending_terms.push_back(terms[k]);
      end
      words_sent++;
   endtask

   task automatic send_load(input logic [1:0] cmd, input logic signed [IN_COEF_W-1:0] coef,
                            input logic [EXPO_IN_W-1:0] expo);
      req_word_type w;
      w.command = cmd;
      w.coef_in = coef;
      w.expo_in = expo;
      send_word(w);
   endtask

   task automatic send_random_product();
      int style;
      int n;
      logic [EXPO_IN_W-1:0] hot;
      style = $urandom_range(0, 9);
      if (style == 0) begin
         for (int e = 0; e <= MAX_EXP; e++) begin
            send_load(CMD_LOAD_FIRST, pick_coef(), EXPO_IN_W'(e));
            send_load(CMD_LOAD_SECOND, pick_coef(), EXPO_IN_W'(e));
         end
      end else if (style == 1) begin
         // pile extremes on one exponent to force saturation
         hot = EXPO_IN_W'($urandom_range(0, MAX_EXP));
         n = $urandom_range(2, 8);
         repeat (n) begin
            send_load($urandom_range(0, 1) ? CMD_LOAD_FIRST : CMD_LOAD_SECOND,
                      $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, hot);
         end
      end else begin
         n = $urandom_range(0, 12);
         repeat (n) begin
            if ($urandom_range(0, 14) == 0)
               send_load(CMD_UNUSED, IN_COEF_W'($urandom), EXPO_IN_W'($urandom));
            else
               send_load($urandom_range(0, 1) ? CMD_LOAD_FIRST : CMD_LOAD_SECOND,
                         pick_coef(), pick_expo());
         end
      end
      send_load(CMD_MULTIPLY, IN_COEF_W'($urandom), EXPO_IN_W'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic note_mismatch(input string field, input longint want, input longint got);
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_terms.size() == 0) begin
            $display("%0t unexpected word: expected none, actual coef %0d expo %0d",
                     $time, rsp_word.coef_out, rsp_word.expo_out);
            fail_count++;
         end else begin
            want = pending_terms.pop_front();
            terms_checked++;
            if (want.empty_product) empties_checked++;
            if (rsp_word.coef_out !== want.coef_out)
               note_mismatch("coef_out", longint'(want.coef_out),
                             longint'(rsp_word.coef_out));
            if (rsp_word.expo_out !== want.expo_out)
               note_mismatch("expo_out", longint'(want.expo_out),
                             longint'(rsp_word.expo_out));
            if (rsp_word.last_term !== want.last_term)
               note_mismatch("last_term", longint'(want.last_term),
                             longint'(rsp_word.last_term));
            if (rsp_word.empty_product !== want.empty_product)
               note_mismatch("empty_product", longint'(want.empty_product),
                             longint'(rsp_word.empty_product));
            if (rsp_word.overflow !== want.overflow)
               note_mismatch("overflow", longint'(want.overflow),
                             longint'(rsp_word.overflow));
         end
      end
   end

   // receiver stall pattern
   initial begin
      int seg_len;
      int mode;
      int hold_cnt;
      seg_len  = 0;
      mode     = 0;
      hold_cnt = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_len == 0) begin
               mode    = $urandom_range(0, 3);
               seg_len = $urandom_range(10, 80);
            end
            seg_len--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= (seg_len % 4 == 0);
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      clear_terms();

      add_row(CMD_MULTIPLY, 0, 0, 1'b1, mk_term(0, 0, 1'b1, 1'b1, 1'b0));
      add_row(CMD_LOAD_FIRST, 1, 0);
      add_row(CMD_LOAD_SECOND, 1, 0);
      add_row(CMD_MULTIPLY, 0, 0, 1'b1, mk_term(1, 0, 1'b1, 1'b0, 1'b0));
      add_row(CMD_LOAD_FIRST, 32767, MAX_EXP);
      add_row(CMD_LOAD_FIRST, 32767, MAX_EXP);
      add_row(CMD_LOAD_FIRST, -32768, 0);
      add_row(CMD_LOAD_FIRST, -32768, 0);
      add_row(CMD_LOAD_SECOND, -32768, MAX_EXP);
      add_row(CMD_LOAD_SECOND, 32767, 0);
      add_row(CMD_LOAD_SECOND, 7, 63);
      add_row(CMD_UNUSED, -1, 63);
      add_row(CMD_MULTIPLY, -1, 63);
      add_row(CMD_LOAD_FIRST, 5, MAX_EXP + 1);
      add_row(CMD_MULTIPLY, 0, 0, 1'b1, mk_term(0, 0, 1'b1, 1'b1, 1'b1));
      add_row(CMD_LOAD_FIRST, 1, 1);
      add_row(CMD_LOAD_FIRST, 1, 0);
      add_row(CMD_LOAD_SECOND, 1, 1);
      add_row(CMD_LOAD_SECOND, -1, 0);
      add_row(CMD_MULTIPLY, 0, 0);
      add_row(CMD_LOAD_FIRST, 9, 3);
      add_row(CMD_LOAD_FIRST, -9, 3);
      add_row(CMD_LOAD_SECOND, 4, 2);
      add_row(CMD_MULTIPLY, 0, 0, 1'b1, mk_term(0, 0, 1'b1, 1'b1, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) send_word(plan[k].word, plan[k].typed, plan[k].term);
      wait_drained();

      hold_pending = 1'b1;
      while (words_sent < WORD_TARGET) begin
         send_random_product();
         if (!mid_pause_done && words_sent > WORD_TARGET / 2) begin
            wait_drained();
            mid_pause_done = 1'b1;
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words and %0d multiplies; checked %0d product terms (%0d empty).",
               words_sent, products_sent, terms_checked, empties_checked);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
